// ===== rtl/fcull_pkg.sv =====
// Shared types and constants for the frustum culling block.
`default_nettype none

package fcull_pkg;

    localparam int VEC_W        = 32;
    localparam int EXT_W        = 31;
    localparam int KIND_W       = 2;
    localparam int SLOT_W       = 3;
    localparam int NUM_PLANES_D = 6;
    localparam int FRAC_BITS_D  = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 2'd0,
        KIND_BOX    = 2'd1,
        KIND_SPHERE = 2'd2
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } fsm_state_t;

endpackage

`default_nettype wire

// ===== rtl/frustum_cull_aabb_sphere.sv =====
// Six-plane frustum culling of boxes and spheres over a plane memory.
// A plane write leaves busy low, and the next request may follow at once.
// A box or sphere test holds busy while one plane per cycle is read from the plane
// memory and flows through a multiply, an add and a sign stage.
// The result strobe (done) rises as busy drops; a new request is accepted only once
// busy drops, so the block takes no test while one runs. Reset clears the per-plane
// valid bits: an unloaded plane reads as zero and culls only a negative-radius sphere.
`default_nettype none

module frustum_cull_aabb_sphere #(
    parameter int NUM_PLANES    = fcull_pkg::NUM_PLANES_D,
    parameter int FRACTION_BITS = fcull_pkg::FRAC_BITS_D
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic        [fcull_pkg::KIND_W-1:0] kind,
    input  wire logic        [fcull_pkg::SLOT_W-1:0] plane_slot,
    input  wire logic signed [fcull_pkg::VEC_W-1:0]  vec_x,
    input  wire logic signed [fcull_pkg::VEC_W-1:0]  vec_y,
    input  wire logic signed [fcull_pkg::VEC_W-1:0]  vec_z,
    input  wire logic        [fcull_pkg::EXT_W-1:0]  extent_x,
    input  wire logic        [fcull_pkg::EXT_W-1:0]  extent_y,
    input  wire logic        [fcull_pkg::EXT_W-1:0]  extent_z,
    input  wire logic signed [fcull_pkg::VEC_W-1:0]  scalar,
    output logic                                     done,
    output logic                                     visible
);
    import fcull_pkg::*;

    localparam int CNT_W   = $clog2(NUM_PLANES + 1);
    localparam int ADDR_W  = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int SEL_W   = CNT_W + SLOT_W;
    localparam int ENTRY_W = 4 * VEC_W;
    localparam int OP_W    = VEC_W + 1;
    localparam int PROD_W  = VEC_W + OP_W;
    localparam int OFS_W   = VEC_W + 1;
    localparam int SHIFT_W = OFS_W + FRACTION_BITS;
    localparam int SUM_W   = ((PROD_W > SHIFT_W) ? PROD_W : SHIFT_W) + 2;

    // Plane memory: {offset, nz, ny, nx} per entry.
    logic [ENTRY_W-1:0] plane_mem [NUM_PLANES];
    logic [NUM_PLANES-1:0] plane_vld_reg;

    fsm_state_t state_reg, state_next;
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;

    logic accept;
    logic wr_en;
    logic issue;
    logic issue_last;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    // Request operands, captured at acceptance.
    logic signed [VEC_W-1:0] cen_reg [3];
    logic        [EXT_W-1:0] ext_reg [3];
    logic signed [VEC_W-1:0] rad_reg;
    logic                    is_box_reg;

    // Read stage.
    logic               rd_vld_reg;
    logic               rd_last_reg;
    logic [ENTRY_W-1:0] rdata_reg;
    logic               plane_ok_reg;

    // Multiply stage.
    logic                     mul_vld_reg;
    logic                     mul_last_reg;
    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [OFS_W-1:0]  ofs_reg, ofs_next;
    logic signed [VEC_W-1:0]  nrm [3];
    logic signed [VEC_W-1:0]  pofs;
    logic signed [OP_W-1:0]   op [3];

    // Add stage.
    logic                    sum_vld_reg;
    logic                    sum_last_reg;
    logic signed [SUM_W-1:0] sum_a_reg, sum_b_reg;
    logic signed [SUM_W-1:0] total;
    logic                    plane_culls;

    logic culled_reg, culled_next;
    logic done_reg, done_next;
    logic visible_reg, visible_next;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign wr_en   = accept && (kind == KIND_WRITE) &&
                     (SEL_W'(plane_slot) < SEL_W'(NUM_PLANES));
    assign wr_addr = ADDR_W'(plane_slot);
    assign rd_addr = issue_cnt_reg[ADDR_W-1:0];
    assign issue      = (state_reg == ST_RUN) && (issue_cnt_reg < CNT_W'(NUM_PLANES));
    assign issue_last = (issue_cnt_reg == CNT_W'(NUM_PLANES - 1));

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_BOX || kind == KIND_SPHERE))
                begin
                    state_next     = ST_RUN;
                    issue_cnt_next = '0;
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if (sum_vld_reg && sum_last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
        end
    end

    // Memory port: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            plane_mem[wr_addr] <= {scalar, vec_z, vec_y, vec_x};
        end
        rdata_reg <= plane_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_vld_reg <= '0;
            plane_ok_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                plane_vld_reg[wr_addr] <= 1'b1;
            end
            plane_ok_reg <= plane_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cen_reg[0] <= vec_x;
            cen_reg[1] <= vec_y;
            cen_reg[2] <= vec_z;
            ext_reg[0] <= extent_x;
            ext_reg[1] <= extent_y;
            ext_reg[2] <= extent_z;
            rad_reg    <= scalar;
            is_box_reg <= (kind == KIND_BOX);
        end
    end

    // For a box, |n|*e equals n*(+e) or n*(-e) by the sign of n, so each lane
    // needs only one multiply: n * (c +/- e).
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nrm[k] = plane_ok_reg ? rdata_reg[k*VEC_W +: VEC_W] : '0;
            if (is_box_reg)
            begin
                if (nrm[k][VEC_W-1])
                begin
                    op[k] = OP_W'(cen_reg[k]) - signed'({2'b00, ext_reg[k]});
                end
                else
                begin
                    op[k] = OP_W'(cen_reg[k]) + signed'({2'b00, ext_reg[k]});
                end
            end
            else
            begin
                op[k] = OP_W'(cen_reg[k]);
            end
            prod_next[k] = PROD_W'(nrm[k]) * PROD_W'(op[k]);
        end
        pofs     = plane_ok_reg ? rdata_reg[3*VEC_W +: VEC_W] : '0;
        ofs_next = OFS_W'(pofs) + (is_box_reg ? OFS_W'(0) : OFS_W'(rad_reg));
    end

    always_ff @(posedge clk)
    begin
        prod_reg[0] <= prod_next[0];
        prod_reg[1] <= prod_next[1];
        prod_reg[2] <= prod_next[2];
        ofs_reg     <= ofs_next;
        sum_a_reg   <= SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]);
        sum_b_reg   <= SUM_W'(prod_reg[2]) + (SUM_W'(ofs_reg) <<< FRACTION_BITS);
    end

    assign total       = sum_a_reg + sum_b_reg;
    assign plane_culls = total[SUM_W-1];

    always_comb
    begin
        culled_next  = culled_reg;
        done_next    = 1'b0;
        visible_next = visible_reg;
        if (accept)
        begin
            culled_next = 1'b0;
        end
        else if (sum_vld_reg)
        begin
            culled_next = culled_reg | plane_culls;
            if (sum_last_reg)
            begin
                done_next    = 1'b1;
                visible_next = !(culled_reg | plane_culls);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            rd_last_reg  <= 1'b0;
            mul_vld_reg  <= 1'b0;
            mul_last_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
            sum_last_reg <= 1'b0;
            culled_reg   <= 1'b0;
            done_reg     <= 1'b0;
            visible_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= issue;
            rd_last_reg  <= issue && issue_last;
            mul_vld_reg  <= rd_vld_reg;
            mul_last_reg <= rd_last_reg;
            sum_vld_reg  <= mul_vld_reg;
            sum_last_reg <= mul_last_reg;
            culled_reg   <= culled_next;
            done_reg     <= done_next;
            visible_reg  <= visible_next;
        end
    end

    assign done    = done_reg;
    assign visible = visible_reg;

    // A result only follows the end of a test pass.
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_RUN))
        else $error("result strobe without a finished test pass");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(rd_vld_reg || mul_vld_reg || sum_vld_reg))
        else $error("plane pipeline busy while idle");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue_cnt_reg <= CNT_W'(NUM_PLANES))
        else $error("plane counter past the table");

    a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_BOX || kind == KIND_SPHERE)) |=> busy)
        else $error("test request did not start a pass");

endmodule

`default_nettype wire
